### hw/rtl/stm_pkg.sv
// Package with the item types and constants of the stepper ramp generator.
`timescale 1ns / 1ps
`default_nettype none
package stm_pkg;
  typedef struct packed {
    logic        action;
    logic [31:0] now_us;
    logic [31:0] target_position;
  } stm_in_t;

  typedef struct packed {
    logic        moving;
    logic        stepped;
    logic        direction;
    logic [3:0]  phase_index;
    logic        holding;
    logic [31:0] position;
    logic [31:0] interval_us;
  } stm_out_t;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;
  localparam logic CFG_MAX_SPEED = 1'b0;
  localparam logic CFG_ACCEL     = 1'b1;
  localparam logic [23:0] RAMP_MAX = 24'hFFFFFF;
  localparam logic [35:0] MICROS_Q16 = 36'd65536000000;
endpackage
`default_nettype wire

### hw/rtl/stepper_trapezoid_microstepper.sv
// Top level of the microstepping trapezoidal ramp generator.
`timescale 1ns / 1ps
`default_nettype none
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_ready | stm_in_t (action, now_us, target)
//  out_    | output    | out_valid/out_ready | stm_out_t (state after the item)
//  cfg_    | input     | cfg_we            | cfg_idx selects max_speed or acceleration
// A set-target item, or a tick that does not step, passes from S_IDLE through
// S_DONE to S_OUT. A stepping tick runs a restoring divide for the stopping
// distance, a square root and an interval divide in the back end's shared
// shift-subtract datapath; when the speed is capped at max_speed the square
// root is skipped.
// Reset clears all ramp state and loads max_speed 1000 and acceleration 500.
// A two-item queue lets the front accept items while the back end works or
// waits for out_ready; the result register holds until it is taken.
module stepper_trapezoid_microstepper
  import stm_pkg::*;
#(
  parameter int PHASE_COUNT   = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [19:0] cfg_wd,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire stm_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output stm_out_t         out_data
);
  logic    q_valid, q_take;
  stm_in_t q_data;

  stm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .q_valid, .q_take, .q_data
  );

  stm_back #(.PHASE_COUNT(PHASE_COUNT), .POSITION_BITS(POSITION_BITS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wd, .q_valid, .q_take, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

### hw/rtl/stm_front.sv
// Front end: accepts items and holds them in a short queue for the ramp engine.
`timescale 1ns / 1ps
`default_nettype none
module stm_front
  import stm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire stm_in_t in_data,
  output logic         q_valid,
  input  wire logic    q_take,
  output stm_in_t      q_data
);
  stm_in_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_take && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_take && q_valid};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/stm_back.sv
// Back end: ramp state, stopping distance, square root and interval divide.
`timescale 1ns / 1ps
`default_nettype none
module stm_back
  import stm_pkg::*;
#(
  parameter int PHASE_COUNT   = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [19:0] cfg_wd,
  input  wire logic        q_valid,
  output logic             q_take,
  input  wire stm_in_t     q_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output stm_out_t         out_data
);
  localparam int PW = $clog2(PHASE_COUNT);
  localparam int PB = POSITION_BITS;
  localparam logic [PW-1:0] PH_LAST = PW'(PHASE_COUNT - 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_DIVD = 4'd2, S_RAMP = 4'd3,
                         S_PROD = 4'd4, S_SQRT = 4'd5, S_IDIV = 4'd6, S_DONE = 4'd7,
                         S_OUT = 4'd8, S_SQ2 = 4'd9;

  logic [3:0]  st_r;
  logic [14:0] vmax_r;
  logic [19:0] acc_r;
  logic [PB-1:0] tgt_r, pos_r;
  logic [23:0] n_r;
  logic [31:0] spd_r, ivl_r, last_r;
  logic [PW-1:0] ph_r;
  logic        hold_r, stp_r, dir_r, fwd_r;
  logic [31:0] now_r;
  logic [PB:0] rem_r;
  logic [63:0] w_r;     // shared working value: square, product, remainder
  logic [63:0] q_r;     // shared quotient / root
  logic [63:0] bit_r;
  logic [6:0]  k_r;
  logic [47:0] lo_r;    // low partial product while squaring

  logic [19:0] a_eff;
  logic [14:0] vm_eff;
  assign a_eff  = (acc_r == 20'd0) ? 20'd1 : acc_r;
  assign vm_eff = (vmax_r == 15'd0) ? 15'd1 : vmax_r;

  // The distance is taken one bit wider so that targets more than half the
  // position range away still give the right direction and magnitude.
  logic [PB:0] diff;
  assign diff = {tgt_r[PB-1], tgt_r} - {pos_r[PB-1], pos_r};
  logic [PB-1:0] tin;
  assign tin = q_data.target_position[PB-1:0];

  logic [21:0] two_a;
  assign two_a = {1'b0, a_eff, 1'b0};
  logic [47:0] lo_p;
  assign lo_p = {32'd0, spd_r[15:0]} * {16'd0, spd_r};
  logic [47:0] hi_p;
  assign hi_p = {32'd0, spd_r[31:16]} * {16'd0, spd_r};
  logic [45:0] prod_w;
  assign prod_w = {24'd0, two_a} * {22'd0, n_r};
  logic [29:0] vsq_w;
  assign vsq_w = {15'd0, vm_eff} * {15'd0, vm_eff};
  logic [64:0] dtrial;
  assign dtrial = {w_r[63:0], q_r[63]} - {43'd0, two_a};
  logic [64:0] strial;
  assign strial = {1'b0, w_r} - {1'b0, q_r} - {1'b0, bit_r};
  logic [36:0] itrial;
  assign itrial = {w_r[35:0], q_r[35]} - {5'd0, spd_r};

  assign q_take = (st_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vmax_r <= 15'd1000; acc_r <= 20'd500;
      tgt_r <= '0; pos_r <= '0; n_r <= '0; spd_r <= '0; ivl_r <= '0; last_r <= '0;
      ph_r <= '0; hold_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_MAX_SPEED) vmax_r <= cfg_wd[14:0];
        else acc_r <= cfg_wd;
      end
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          stp_r <= 1'b0; dir_r <= 1'b0; now_r <= q_data.now_us;
          if (q_data.action == ACT_SET) begin
            if (tin != tgt_r) begin
              tgt_r <= tin;
              if (pos_r == tin) begin n_r <= '0; spd_r <= '0; end
            end
            st_r <= S_DONE;
          end else if (tgt_r == pos_r) begin
            spd_r <= '0; n_r <= '0; hold_r <= 1'b1; st_r <= S_DONE;
          end else begin
            hold_r <= 1'b0;
            if (q_data.now_us - last_r >= ivl_r) begin
              fwd_r <= ~diff[PB];
              rem_r <= diff[PB] ? -diff : diff;
              lo_r  <= lo_p;
              st_r  <= S_SQ;
            end else st_r <= S_DONE;
          end
        end
        S_SQ: begin
          w_r <= {16'd0, lo_r} + {hi_p, 16'd0};
          st_r <= S_SQ2;
        end
        S_SQ2: begin
          // restoring divide of the speed square by 2a, one bit a cycle
          q_r <= w_r; w_r <= '0; k_r <= 7'd0; st_r <= S_DIVD;
        end
        S_DIVD: begin
          if (!dtrial[64]) begin
            w_r <= dtrial[63:0]; q_r <= {q_r[62:0], 1'b1};
          end else begin
            w_r <= {w_r[62:0], q_r[63]}; q_r <= {q_r[62:0], 1'b0};
          end
          k_r <= k_r + 7'd1;
          if (k_r == 7'd63) st_r <= S_RAMP;
        end
        S_RAMP: begin
          if ({{(63-PB){1'b0}}, rem_r} <= {32'd0, q_r[63:32]}) begin
            n_r <= (n_r <= 24'd1) ? 24'd1 : n_r - 24'd1;
          end else if (spd_r < {1'b0, vm_eff, 16'd0}) begin
            if (n_r < RAMP_MAX) n_r <= n_r + 24'd1;
          end
          st_r <= S_PROD;
        end
        S_PROD: begin
          w_r <= {18'd0, prod_w};
          st_r <= S_SQRT; k_r <= 7'd0;
        end
        S_SQRT: begin
          if (k_r == 7'd0) begin
            if ({18'd0, w_r[45:0]} >= {34'd0, vsq_w}) begin
              spd_r <= {1'b0, vm_eff, 16'd0}; k_r <= 7'd40;
            end else begin
              w_r <= {w_r[31:0], 32'd0}; q_r <= '0; bit_r <= 64'd1 << 62;
              k_r <= 7'd1;
            end
          end else if (k_r == 7'd40) begin
            // A zero speed divides to all ones, the saturated interval.
            w_r <= '0; q_r <= {28'd0, MICROS_Q16}; k_r <= 7'd0;
            st_r <= S_IDIV;
          end else begin
            if (!strial[64]) begin
              w_r <= strial[63:0]; q_r <= (q_r >> 1) + bit_r;
            end else q_r <= q_r >> 1;
            bit_r <= bit_r >> 2;
            if (k_r == 7'd32) begin
              spd_r <= (!strial[64]) ? 32'((q_r >> 1) + bit_r) : 32'(q_r >> 1);
              k_r <= 7'd40;
            end else k_r <= k_r + 7'd1;
          end
        end
        S_IDIV: begin
          if (!itrial[36]) begin
            w_r <= {28'd0, itrial[35:0]}; q_r <= {q_r[62:0], 1'b1};
          end else begin
            w_r <= {28'd0, w_r[34:0], q_r[35]}; q_r <= {q_r[62:0], 1'b0};
          end
          k_r <= k_r + 7'd1;
          if (k_r == 7'd35) begin
            ivl_r <= !itrial[36] ? {q_r[30:0], 1'b1} : {q_r[30:0], 1'b0};
            if (fwd_r) begin
              ph_r <= (ph_r >= PH_LAST) ? '0 : ph_r + PW'(1);
              pos_r <= pos_r + PB'(1);
            end else begin
              ph_r <= (ph_r == '0 || ph_r > PH_LAST) ? PH_LAST : ph_r - PW'(1);
              pos_r <= pos_r - PB'(1); dir_r <= 1'b1;
            end
            last_r <= now_r; stp_r <= 1'b1; st_r <= S_DONE;
          end
        end
        S_DONE: begin out_valid <= 1'b1; st_r <= S_OUT; end
        S_OUT: if (out_ready) begin out_valid <= 1'b0; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  logic [31:0] pos_ext;
  assign pos_ext = 32'($signed(pos_r));
  assign out_data = '{moving: (pos_r != tgt_r), stepped: stp_r, direction: dir_r,
                      phase_index: 4'(ph_r), holding: hold_r, position: pos_ext,
                      interval_us: ivl_r};
endmodule
`default_nettype wire

### tb/sv/tb_stepper_trapezoid_microstepper.sv
// Self-checking testbench for the microstepping trapezoidal ramp generator.
`timescale 1ns / 1ps
module tb_stepper_trapezoid_microstepper;
  import stm_pkg::*;

  // The block is driven from a short table of directed items and then from
  // random move sequences under several register settings. Every result item
  // is compared field by field with the oldest expectation in ramp_expected,
  // which is filled at input acceptance from the ramp predictor below.

  localparam int PHASES     = 16;
  localparam int WATCH_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [19:0] cfg_wd;
  logic        in_valid;
  logic        in_ready;
  stm_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  stm_out_t    out_data;

  stepper_trapezoid_microstepper dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wd(cfg_wd),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: a private copy of the configuration and ramp registers.
  logic [14:0]        m_max_speed;
  logic [19:0]        m_accel;
  logic signed [31:0] m_target;
  logic signed [31:0] m_position;
  logic [23:0]        m_count;
  logic [31:0]        m_speed;
  logic [31:0]        m_interval;
  logic [31:0]        m_last_step;
  logic [3:0]         m_phase;
  logic               m_hold;

  stm_out_t ramp_expected[$];
  int       fail_count;
  int       items_sent;
  int       results_seen;
  int       steps_seen;
  int       idle_cycles;
  int       burst_left;

  // Bitwise integer square root, as the ramp needs floor(sqrt(x)).
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic stm_out_t ramp_predict(stm_in_t it);
    stm_out_t        o;
    longint unsigned a;
    longint unsigned vmax;
    longint unsigned vsq;
    longint unsigned decel;
    longint unsigned prod;
    longint unsigned remaining;
    longint          diff;
    logic [31:0]     elapsed;
    bit              fwd;
    o = '0;
    if (it.action == ACT_SET) begin
      if ($signed(it.target_position) != m_target) begin
        m_target = it.target_position;
        // A new target that equals the position drops the ramp.
        if (m_position == m_target) begin
          m_count = '0;
          m_speed = '0;
        end
      end
    end else if (m_target == m_position) begin
      // Tick at target: ramp cleared, hold raised, interval kept.
      m_speed = '0;
      m_count = '0;
      m_hold  = 1'b1;
    end else begin
      m_hold  = 1'b0;
      elapsed = it.now_us - m_last_step;
      if (elapsed >= m_interval) begin
        // Zero registers act as one.
        a    = (m_accel == 0) ? 64'd1 : 64'(m_accel);
        vmax = (m_max_speed == 0) ? 64'd1 : 64'(m_max_speed);
        diff = longint'(m_target) - longint'(m_position);
        fwd  = diff > 0;
        remaining = fwd ? diff : -diff;
        vsq   = 64'(m_speed) * 64'(m_speed);
        decel = (vsq / (2 * a)) >> 32;
        if (remaining <= decel) begin
          m_count = (m_count <= 1) ? 24'd1 : m_count - 24'd1;
        end else if (64'(m_speed) < (vmax << 16)) begin
          if (m_count != RAMP_MAX) m_count = m_count + 24'd1;
        end
        prod = 2 * a * 64'(m_count);
        if (prod >= vmax * vmax) m_speed = 32'(vmax << 16);
        else m_speed = 32'(int_sqrt(prod << 32));
        if (m_speed == 0) m_interval = 32'hFFFF_FFFF;
        else m_interval = 32'(64'(MICROS_Q16) / 64'(m_speed));
        if (fwd) begin
          m_phase    = (m_phase == PHASES - 1) ? 4'd0 : m_phase + 4'd1;
          m_position = m_position + 32'sd1;
        end else begin
          m_phase    = (m_phase == 0) ? 4'(PHASES - 1) : m_phase - 4'd1;
          m_position = m_position - 32'sd1;
          o.direction = 1'b1;
        end
        m_last_step = it.now_us;
        o.stepped   = 1'b1;
      end
    end
    o.moving      = (m_position != m_target);
    o.phase_index = m_phase;
    o.holding     = m_hold;
    o.position    = m_position;
    o.interval_us = m_interval;
    return o;
  endfunction

  // Sends one item in bursts with random gaps; the expectation is queued at
  // the edge where the item is taken. A typed expectation overrides the
  // predicted one, while the predictor still advances its state.
  task automatic send_item(stm_in_t it, bit typed, stm_out_t typed_res);
    stm_out_t pred;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = ramp_predict(it);
    ramp_expected.push_back(typed ? typed_res : pred);
    items_sent = items_sent + 1;
  endtask

  // Waits until every expected result has come, then lets the back end settle.
  task automatic drain_results();
    while (ramp_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic write_config(logic [14:0] ms, logic [19:0] ac);
    cfg_we  <= 1'b1;
    cfg_idx <= CFG_MAX_SPEED;
    cfg_wd  <= 20'(ms);
    @(posedge clk);
    m_max_speed = ms;
    cfg_idx <= CFG_ACCEL;
    cfg_wd  <= ac;
    @(posedge clk);
    m_accel = ac;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random item: mostly well-formed moves with ticks timed around the step
  // interval, plus noise in the timestamp and the odd far-off target.
  task automatic send_random_item();
    stm_in_t it;
    int      pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 14 || m_position == m_target && pick < 40) begin
      it.action = ACT_SET;
      pick = $urandom_range(0, 19);
      if (pick == 0) it.target_position = $urandom();
      else if (pick == 1) it.target_position = m_target;
      else if (pick == 2) it.target_position = m_position;
      else it.target_position = m_position + $signed(32'($urandom_range(0, 80)) - 32'sd40);
    end else begin
      it.action = ACT_TICK;
      it.target_position = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 72) it.now_us = m_last_step + m_interval + $urandom_range(0, 3);
      else if (pick < 86) it.now_us = m_last_step + $urandom_range(0, m_interval);
      else if (pick < 96) it.now_us = $urandom();
      else it.now_us = 32'hFFFF_FFF0 + $urandom_range(0, 31);
    end
    send_item(it, 1'b0, '0);
  endtask

  // The receiver cycles through three out_ready patterns of its own: always ready, random stalls and a periodic stall.
  int rx_count;
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    case ((rx_count / 400) % 3)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ((rx_count % 11) > 3);
      end
    endcase
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (ramp_expected.size() == 0) begin
        $display("%0t: unexpected result item %h", $realtime, out_data);
        fail_count = fail_count + 1;
      end else begin
        stm_out_t e;
        e = ramp_expected.pop_front();
        results_seen <= results_seen + 1;
        if (out_data.stepped) steps_seen <= steps_seen + 1;
        if (out_data.moving !== e.moving) begin
          $display("%0t: moving expected %0d actual %0d", $realtime, e.moving, out_data.moving);
          fail_count = fail_count + 1;
        end
        if (out_data.stepped !== e.stepped) begin
          $display("%0t: stepped expected %0d actual %0d", $realtime, e.stepped,
                   out_data.stepped);
          fail_count = fail_count + 1;
        end
        if (out_data.direction !== e.direction) begin
          $display("%0t: direction expected %0d actual %0d", $realtime, e.direction,
                   out_data.direction);
          fail_count = fail_count + 1;
        end
        if (out_data.phase_index !== e.phase_index) begin
          $display("%0t: phase_index expected %0d actual %0d", $realtime, e.phase_index,
                   out_data.phase_index);
          fail_count = fail_count + 1;
        end
        if (out_data.holding !== e.holding) begin
          $display("%0t: holding expected %0d actual %0d", $realtime, e.holding,
                   out_data.holding);
          fail_count = fail_count + 1;
        end
        if (out_data.position !== e.position) begin
          $display("%0t: position expected %0d actual %0d", $realtime, $signed(e.position),
                   $signed(out_data.position));
          fail_count = fail_count + 1;
        end
        if (out_data.interval_us !== e.interval_us) begin
          $display("%0t: interval_us expected %0d actual %0d", $realtime, e.interval_us,
                   out_data.interval_us);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $realtime,
               ramp_expected.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  typedef struct {
    bit       typed;
    stm_in_t  it;
    stm_out_t res;
  } stim_row_t;

  stim_row_t directed_rows[$];

  task automatic add_row(logic act, logic [31:0] now, logic [31:0] tgt, bit typed,
                         stm_out_t res);
    stim_row_t r;
    r.typed = typed;
    r.it    = '{act, now, tgt};
    r.res   = res;
    directed_rows.push_back(r);
  endtask

  logic [14:0] speed_set[6];
  logic [19:0] accel_set[6];

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wd = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    rx_count = 0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    steps_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    m_max_speed = 15'd1000;
    m_accel = 20'd500;
    m_target = '0;
    m_position = '0;
    m_count = '0;
    m_speed = '0;
    m_interval = '0;
    m_last_step = '0;
    m_phase = '0;
    m_hold = 1'b0;

    // Tick at target right after reset, then the positive extreme target set
    // twice (the second one must change nothing), then steps with huge gaps,
    // a timestamp wrap, the negative extreme, a target equal to the position,
    // and a reverse run that wraps the phase below zero.
    add_row(ACT_TICK, 32'd0, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd0, 1'b1, 32'd0, 32'd0});
    add_row(ACT_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
            '{1'b1, 1'b0, 1'b0, 4'd0, 1'b1, 32'd0, 32'd0});
    add_row(ACT_SET, 32'd0, 32'h7FFF_FFFF, 1'b1,
            '{1'b1, 1'b0, 1'b0, 4'd0, 1'b1, 32'd0, 32'd0});
    add_row(ACT_TICK, 32'd0, 32'h8000_0000, 1'b0, '0);
    add_row(ACT_TICK, 32'd1, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ACT_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, '0);
    add_row(ACT_SET, 32'd5, 32'h8000_0000, 1'b0, '0);
    add_row(ACT_TICK, 32'h0000_FFFF, 32'd0, 1'b0, '0);
    add_row(ACT_SET, 32'd0, 32'd1, 1'b0, '0);
    add_row(ACT_TICK, 32'h1000_0000, 32'd0, 1'b0, '0);
    add_row(ACT_SET, 32'd0, 32'hFFFF_FFFD, 1'b0, '0);
    for (int k = 0; k < 6; k++) add_row(ACT_TICK, 32'h2000_0000 * (k + 1), 32'd0, 1'b0, '0);
    add_row(ACT_TICK, 32'hF000_0000, 32'd0, 1'b0, '0);
    add_row(ACT_SET, 32'd0, 32'd0, 1'b0, '0);

    // Settings: the reset values first, then extremes and zeros.
    speed_set = '{15'd1000, 15'd1, 15'd20000, 15'd0, 15'h7FFF, 15'd300};
    accel_set = '{20'd500, 20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd40000};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i].it, directed_rows[i].typed,
                                         directed_rows[i].res);
    in_valid <= 1'b0;
    // The sender holds off here until every result has come back.
    drain_results();

    for (int s = 0; s < 6; s++) begin
      write_config(speed_set[s], accel_set[s]);
      for (int k = 0; k < 310; k++) send_random_item();
      in_valid <= 1'b0;
      burst_left = 0;
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items over 6 register settings; %0d results checked, %0d steps.",
             items_sent, results_seen, steps_seen);
    if (fail_count == 0 && ramp_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, ramp_expected.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### stepper_trapezoid_microstepper.f
hw/rtl/stm_pkg.sv
hw/rtl/stm_front.sv
hw/rtl/stm_back.sv
hw/rtl/stepper_trapezoid_microstepper.sv
tb/sv/tb_stepper_trapezoid_microstepper.sv
